FILE: design/five_byte_frame_deframer_defines.svh
// Assertion macros for the five-byte frame deframer.
`ifndef FIVE_BYTE_FRAME_DEFRAMER_DEFINES_SVH
`define FIVE_BYTE_FRAME_DEFRAMER_DEFINES_SVH

// Clocked check, disabled while reset is asserted.
`define FBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define FBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fbd_pkg.sv
// Shared types and constants for the five-byte frame deframer.
`default_nettype none

package fbd_pkg;

    localparam int unsigned WinDepth = 4;
    localparam int unsigned FillW    = 3;

    localparam logic [7:0] IdByteReset = 8'hA3;
    localparam logic [7:0] Mod255      = 8'd255;
    localparam logic [FillW-1:0] FillFull = 3'd4;

    typedef logic [WinDepth-1:0][7:0] t_window;

    typedef struct packed {
        logic hit;
        logic used_mod255;
    } t_check;

endpackage

`default_nettype wire

FILE: design/fbd_check.sv
// Candidate frame test: marker compare and mod-256 / mod-255 checksum match.
`default_nettype none

module fbd_check (
    input  wire fbd_pkg::t_window i_win,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic [7:0]       i_id_byte,
    output fbd_pkg::t_check       o_check
);

    logic [9:0] sum;
    logic [8:0] fold;
    logic [7:0] rem255;
    logic       ok256;
    logic       ok255;
    logic       marker_ok;

    always_comb begin
        sum = {2'b00, i_win[0]} + {2'b00, i_id_byte} + {2'b00, i_win[2]} + {2'b00, i_win[3]};
        // 256 is 1 mod 255, so fold the upper bits back in
        fold = {1'b0, sum[7:0]} + {7'b0, sum[9:8]};
        if (fold >= {1'b0, fbd_pkg::Mod255}) begin
            rem255 = 8'(fold - {1'b0, fbd_pkg::Mod255});
        end else begin
            rem255 = fold[7:0];
        end
        ok256     = (sum[7:0] == i_rx_byte);
        ok255     = !ok256 && (rem255 == i_rx_byte);
        marker_ok = (i_win[1] == i_id_byte);
        o_check.hit         = marker_ok && (ok256 || ok255);
        o_check.used_mod255 = !ok256;
    end

endmodule

`default_nettype wire

FILE: design/fbd_window.sv
// Four-byte window of unconsumed bytes with fill count; slides, fills or empties per item.
`default_nettype none
`include "five_byte_frame_deframer_defines.svh"

module fbd_window (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic [7:0]       i_id_byte,
    output fbd_pkg::t_check       o_check,
    output fbd_pkg::t_window      o_win
);

    fbd_pkg::t_window            r_win;
    fbd_pkg::t_window            n_win;
    logic [fbd_pkg::FillW-1:0]   r_fill;
    logic [fbd_pkg::FillW-1:0]   n_fill;
    fbd_pkg::t_check             cand;
    logic                        full;

    fbd_check u_check (
        .i_win     (r_win),
        .i_rx_byte (i_rx_byte),
        .i_id_byte (i_id_byte),
        .o_check   (cand)
    );

    always_comb begin
        full                = (r_fill == fbd_pkg::FillFull);
        o_check.hit         = full && cand.hit;
        o_check.used_mod255 = cand.used_mod255;
        o_win               = r_win;
    end

    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        if (i_step) begin
            if (!full) begin
                n_win[r_fill[1:0]] = i_rx_byte;
                n_fill             = r_fill + 3'd1;
            end else if (cand.hit) begin
                n_win  = '0;
                n_fill = '0;
            end else begin
                n_win = {i_rx_byte, r_win[3], r_win[2], r_win[1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    `FBD_ASSERT(a_fill_range, r_fill <= fbd_pkg::FillFull, "window fill above four")
    `FBD_ASSERT_NEXT(a_hit_empties, i_step && o_check.hit, r_fill == '0, "frame did not empty window")
    `FBD_ASSERT_NEXT(a_fill_grows, i_step && !full, r_fill == $past(r_fill) + 3'd1, "fill did not advance")

endmodule

`default_nettype wire

FILE: design/five_byte_frame_deframer.sv
// Top level of the five-byte frame deframer: input register, window, result register.
//
// Input channel: i_valid / o_ready carry one received byte (i_rx_byte) per item.
// Output channel: o_valid / i_ready carry one decoded frame: channel, 16-bit value,
// checksum byte and which modulus matched. A frame is channel, marker, value high,
// value low, checksum; the marker must equal the id register.
// Configuration: i_cfg_we writes i_cfg_data into the id register;
// write only while no item is in flight.
// The fifth byte is held in the input register; the window test on it loads the result
// register. Throughput: one byte per cycle unless a held result stalls the input,
// set by the single window-test stage.
// Reset: window empty, no results pending, id register back to 0xA3.
// Stall: a held result blocks only an item that would produce another result;
// bytes that merely fill or slide the window keep flowing. Once the input register
// is blocked, o_ready drops until the receiver takes the result.
`default_nettype none
`include "five_byte_frame_deframer_defines.svh"

module five_byte_frame_deframer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [7:0]  o_channel,
    output logic [15:0] o_value_word,
    output logic [7:0]  o_checksum_byte,
    output logic        o_used_mod255,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_data
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic [7:0]        r_id_byte;
    logic              r_out_valid;
    logic [7:0]        r_channel;
    logic [15:0]       r_value;
    logic [7:0]        r_cksum;
    logic              r_mod255;
    logic              out_free;
    logic              step;
    fbd_pkg::t_check   chk;
    fbd_pkg::t_window  win;

    fbd_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_rx_byte (r_in_byte),
        .i_id_byte (r_id_byte),
        .o_check   (chk),
        .o_win     (win)
    );

    always_comb begin
        out_free = !r_out_valid || i_ready;
        step     = r_in_valid && (!chk.hit || out_free);
        o_ready  = !r_in_valid || step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_id_byte   <= fbd_pkg::IdByteReset;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (step && chk.hit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_id_byte <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (step && chk.hit) begin
            r_channel <= win[0];
            r_value   <= {win[2], win[3]};
            r_cksum   <= r_in_byte;
            r_mod255  <= chk.used_mod255;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_channel       = r_channel;
    assign o_value_word    = r_value;
    assign o_checksum_byte = r_cksum;
    assign o_used_mod255   = r_mod255;

    `FBD_ASSERT_NEXT(a_result_loads, step && chk.hit, o_valid, "frame hit gave no result")
    `FBD_ASSERT_NEXT(a_no_overwrite, o_valid && !i_ready, $stable({r_channel, r_cksum}),
        "held result overwritten")
    `FBD_ASSERT(a_hit_waits, (r_in_valid && chk.hit && !out_free) |-> !step, "hit stepped into full result register")

endmodule

`default_nettype wire

FILE: tb/five_byte_frame_deframer_checker.sv
// Frame predictor and result checker for the five-byte frame deframer testbench.
`timescale 1ns / 1ps

module five_byte_frame_deframer_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [7:0]  i_rx_byte,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [7:0]  i_channel,
    input  wire  [15:0] i_value_word,
    input  wire  [7:0]  i_checksum_byte,
    input  wire         i_used_mod255,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        logic [7:0]  channel;
        logic [15:0] value_word;
        logic [7:0]  checksum_byte;
        logic        used_mod255;
    } t_frame_result;

    fbd_pkg::t_window          window;
    logic [fbd_pkg::FillW-1:0] fill;
    logic [7:0]                id_reg;
    t_frame_result             expected_frames[$];
    t_frame_result             want;
    t_frame_result             got;
    int                        mismatch_count = 0;

    // Shifts one byte into the window; returns 1 when it completes a valid frame.
    function automatic bit absorb_byte(input logic [7:0] rx, output t_frame_result res);
        logic [9:0] sum;
        logic [7:0] sum256;
        logic [7:0] sum255;
        res = '0;
        if (fill < fbd_pkg::FillFull) begin
            window[fill[1:0]] = rx;
            fill = fill + 1'b1;
            return 1'b0;
        end
        if (window[1] == id_reg) begin
            sum    = 10'(window[0]) + 10'(id_reg) + 10'(window[2]) + 10'(window[3]);
            sum256 = sum[7:0];
            sum255 = 8'(sum % 10'(fbd_pkg::Mod255));
            if (sum256 == rx || sum255 == rx) begin
                res.channel       = window[0];
                res.value_word    = {window[2], window[3]};
                res.checksum_byte = rx;
                res.used_mod255   = (sum256 != rx);
                window = '0;
                fill   = '0;
                return 1'b1;
            end
        end
        window = {rx, window[3:1]};
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window = '0;
            fill   = '0;
            id_reg = fbd_pkg::IdByteReset;
            expected_frames.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_channel, i_value_word, i_checksum_byte, i_used_mod255};
                if (expected_frames.size() == 0) begin
                    $error("unexpected frame: channel %0h value %0h checksum %0h",
                           got.channel, got.value_word, got.checksum_byte);
                    mismatch_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (got.channel !== want.channel) begin
                        $error("channel: expected %0h, got %0h", want.channel, got.channel);
                        mismatch_count++;
                    end
                    if (got.value_word !== want.value_word) begin
                        $error("value_word: expected %0h, got %0h",
                               want.value_word, got.value_word);
                        mismatch_count++;
                    end
                    if (got.checksum_byte !== want.checksum_byte) begin
                        $error("checksum_byte: expected %0h, got %0h",
                               want.checksum_byte, got.checksum_byte);
                        mismatch_count++;
                    end
                    if (got.used_mod255 !== want.used_mod255) begin
                        $error("used_mod255: expected %0b, got %0b",
                               want.used_mod255, got.used_mod255);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (absorb_byte(i_rx_byte, want)) begin
                    expected_frames.push_back(want);
                end
            end
            if (i_cfg_we) begin
                id_reg = i_cfg_data;
            end
        end
        o_outstanding <= expected_frames.size();
        o_fail_count  <= mismatch_count;
    end

endmodule

FILE: tb/five_byte_frame_deframer_tb.sv
// Top of the five-byte frame deframer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module five_byte_frame_deframer_tb;

    localparam int PhaseItems     = 205;
    localparam int HoldOffCycles  = 400;
    localparam int WatchdogLimit  = 2000;
    localparam int SettleCycles   = 6;

    typedef enum {SUM_MOD256, SUM_MOD255, SUM_WRONG} t_sum_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_channel;
    logic [15:0] o_value_word;
    logic [7:0]  o_checksum_byte;
    logic        o_used_mod255;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_data;

    int          fail_count;
    int          outstanding;
    logic [7:0]  cur_id = fbd_pkg::IdByteReset;
    int          send_run = 0;
    int          items_in_phase = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    five_byte_frame_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_channel       (o_channel),
        .o_value_word    (o_value_word),
        .o_checksum_byte (o_checksum_byte),
        .o_used_mod255   (o_used_mod255),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    five_byte_frame_deframer_checker frame_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_channel       (o_channel),
        .i_value_word    (o_value_word),
        .i_checksum_byte (o_checksum_byte),
        .i_used_mod255   (o_used_mod255),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    // Idle cycles before the next item; occasional runs with no idling at all.
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            run_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(send_run);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_in_phase++;
    endtask

    task automatic send_frame(input logic [7:0] ch, input logic [7:0] marker,
                              input logic [7:0] hi, input logic [7:0] lo,
                              input t_sum_kind kind);
        logic [9:0] sum;
        logic [7:0] sum256;
        logic [7:0] sum255;
        logic [7:0] ck;
        sum    = 10'(ch) + 10'(marker) + 10'(hi) + 10'(lo);
        sum256 = sum[7:0];
        sum255 = 8'(sum % 10'(fbd_pkg::Mod255));
        case (kind)
            SUM_MOD256: ck = sum256;
            SUM_MOD255: ck = sum255;
            default: begin
                ck = 8'($urandom);
                while (ck == sum256 || ck == sum255) ck = 8'($urandom);
            end
        endcase
        send_byte(ch);
        send_byte(marker);
        send_byte(hi);
        send_byte(lo);
        send_byte(ck);
    endtask

    // Drains outstanding frames, then lets any byte still in the pipe settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_id(input logic [7:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_id = v;
    endtask

    initial begin
        int         phase;
        int         pick;
        logic [7:0] next_id;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_rx_byte  = 8'h00;
        i_cfg_we   = 1'b0;
        i_cfg_data = 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // window filling from reset; sum below 255 so both moduli agree
        send_frame(8'h00, cur_id, 8'h00, 8'h00, SUM_MOD256);
        send_frame(8'hFF, cur_id, 8'hFF, 8'hFF, SUM_MOD255);
        send_frame(8'hFF, cur_id, 8'hFF, 8'hFF, SUM_MOD256);
        // checksum of 255, only reachable mod 256
        send_frame(8'h5C, cur_id, 8'h00, 8'h00, SUM_MOD256);
        send_frame(8'h12, cur_id, 8'h34, 8'h56, SUM_WRONG);

        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0:       next_id = 8'h00;
                1:       next_id = 8'hFF;
                default: next_id = 8'($urandom);
            endcase
            write_id(next_id);
            items_in_phase = 0;
            while (items_in_phase < PhaseItems) begin
                pick = $urandom_range(0, 99);
                if (pick < 38) begin
                    send_frame(8'($urandom), cur_id, 8'($urandom), 8'($urandom), SUM_MOD256);
                end else if (pick < 70) begin
                    send_frame(8'($urandom), cur_id, 8'($urandom), 8'($urandom), SUM_MOD255);
                end else if (pick < 82) begin
                    send_frame(8'($urandom), cur_id, 8'($urandom), 8'($urandom), SUM_WRONG);
                end else if (pick < 90) begin
                    send_frame(8'($urandom), cur_id ^ 8'($urandom_range(1, 255)),
                               8'($urandom), 8'($urandom), SUM_MOD256);
                end else begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
            end
        end
        wait_idle();

        if (fail_count == 0 && outstanding == 0) begin
            $display("five_byte_frame_deframer regression: pass");
        end else begin
            $display("five_byte_frame_deframer regression: fail");
        end
        $finish;
    end

    // Result side; long hold-offs let the block fill up and stall its input.
    initial begin
        int stall;
        int run_left;
        int taken;
        run_left = 0;
        taken    = 0;
        i_ready  = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait(run_left);
            if (taken == 40 || taken == 110) begin
                stall = HoldOffCycles;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < WatchdogLimit) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("five_byte_frame_deframer regression: fail");
        $finish;
    end

endmodule

FILE: five_byte_frame_deframer.f
+incdir+design
design/fbd_pkg.sv
design/fbd_check.sv
design/fbd_window.sv
design/five_byte_frame_deframer.sv
tb/five_byte_frame_deframer_checker.sv
tb/five_byte_frame_deframer_tb.sv
